@@ rtl/core/grt_pkg.sv @@
// shared types, constants and the hat decode for the gamepad report translator
`timescale 1ns / 1ps

package grt_pkg;

  // standard button word layout
  localparam logic [15:0] BTN_UP        = 16'h0001;
  localparam logic [15:0] BTN_DOWN      = 16'h0002;
  localparam logic [15:0] BTN_LEFT      = 16'h0004;
  localparam logic [15:0] BTN_RIGHT     = 16'h0008;
  localparam logic [15:0] BTN_START     = 16'h0010;
  localparam logic [15:0] BTN_BACK      = 16'h0020;
  localparam logic [15:0] BTN_LTHUMB    = 16'h0040;
  localparam logic [15:0] BTN_RTHUMB    = 16'h0080;
  localparam logic [15:0] BTN_LSHOULDER = 16'h0100;
  localparam logic [15:0] BTN_RSHOULDER = 16'h0200;
  localparam logic [15:0] BTN_A         = 16'h1000;
  localparam logic [15:0] BTN_B         = 16'h2000;
  localparam logic [15:0] BTN_X         = 16'h4000;
  localparam logic [15:0] BTN_Y         = 16'h8000;

  // fixed axis values used when the hat drives the left stick, and the sign flip for the stick bytes
  localparam logic [15:0] AX_POS_FULL    = 16'h7FFF;
  localparam logic [15:0] AX_NEG_FULL    = 16'h8000;
  localparam logic [15:0] AX_DIAG_Y      = 16'd29727;
  localparam logic [15:0] AX_DIAG_Y_NEG  = 16'd35809;
  localparam logic [15:0] AX_DIAG_XR     = 16'd19403;
  localparam logic [15:0] AX_DIAG_XL_NEG = 16'd43313;
  localparam logic [15:0] AX_SIGN_FLIP   = 16'h8000;

  localparam logic [7:0]  TRIG_SHORT_BASE = 8'd190;
  localparam logic [11:0] TOUCH_SPLIT_X   = 12'd800;
  localparam logic [6:0]  BATT_MAX        = 7'd100;

  localparam int NUM_PROFILE_BTN = 17;

  typedef enum logic [2:0] {
    REG_MODE = 3'd0,
    REG_MAP0 = 3'd1,
    REG_MAP1 = 3'd2,
    REG_MAP2 = 3'd3,
    REG_MAP3 = 3'd4,
    REG_MAP4 = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    HAT_UP         = 4'd0,
    HAT_UP_RIGHT   = 4'd1,
    HAT_RIGHT      = 4'd2,
    HAT_DOWN_RIGHT = 4'd3,
    HAT_DOWN       = 4'd4,
    HAT_DOWN_LEFT  = 4'd5,
    HAT_LEFT       = 4'd6,
    HAT_UP_LEFT    = 4'd7
  } hat_dir_t;

  typedef struct packed {
    logic touch_split;
    logic hat_stick;
    logic profile;
    logic short_trig;
  } mode_t;

  // mask k of the profile table sits at bits k*16 of this struct
  typedef struct packed {
    logic [15:0] w4;
    logic [63:0] w3;
    logic [63:0] w2;
    logic [63:0] w1;
    logic [63:0] w0;
  } map_cfg_t;

  function automatic logic [15:0] hat_dpad(input logic [3:0] hat);
    logic [15:0] bits;
    begin
      unique case (hat)
        HAT_UP:         bits = BTN_UP;
        HAT_UP_RIGHT:   bits = BTN_UP | BTN_RIGHT;
        HAT_RIGHT:      bits = BTN_RIGHT;
        HAT_DOWN_RIGHT: bits = BTN_DOWN | BTN_RIGHT;
        HAT_DOWN:       bits = BTN_DOWN;
        HAT_DOWN_LEFT:  bits = BTN_DOWN | BTN_LEFT;
        HAT_LEFT:       bits = BTN_LEFT;
        HAT_UP_LEFT:    bits = BTN_UP | BTN_LEFT;
        default:        bits = 16'h0000;  // neutral
      endcase
      return bits;
    end
  endfunction

endpackage

@@ rtl/core/grt_buttons.sv @@
// button word builder: fixed layout or profile masks, hat d-pad and touchpad split
`timescale 1ns / 1ps

module grt_buttons
  import grt_pkg::*;
(
  input  mode_t       mode,
  input  map_cfg_t    map,
  input  logic [7:0]  face_hat_byte,
  input  logic [7:0]  shoulder_byte,
  input  logic [7:0]  extra_byte,
  input  logic [23:0] touch_bytes,
  output logic [15:0] button_bits
);

  logic [NUM_PROFILE_BTN-1:0][15:0] masks;
  logic [NUM_PROFILE_BTN-1:0]       press;
  logic [15:0]                      fixed_bits;
  logic [15:0]                      profile_bits;
  logic [15:0]                      dpad_bits;
  logic [11:0]                      touch_x;
  logic                             touching;
  logic                             sel;
  logic                             sta;

  assign masks     = map;
  assign dpad_bits = hat_dpad(face_hat_byte[3:0]);

  assign touching = ~touch_bytes[7];
  assign touch_x  = {touch_bytes[19:16], touch_bytes[15:8]};
  assign sel = shoulder_byte[4] | (mode.touch_split & touching & (touch_x < TOUCH_SPLIT_X));
  assign sta = shoulder_byte[5] | (mode.touch_split & touching & (touch_x >= TOUCH_SPLIT_X));

  assign press = {extra_byte[7], extra_byte[6], extra_byte[5], extra_byte[4],
                  extra_byte[2], extra_byte[0], extra_byte[1],
                  shoulder_byte[7], shoulder_byte[6], sta, sel,
                  shoulder_byte[1], shoulder_byte[0],
                  face_hat_byte[7], face_hat_byte[6], face_hat_byte[5], face_hat_byte[4]};

  always_comb begin
    profile_bits = 16'h0000;
    for (int k = 0; k < NUM_PROFILE_BTN; k++) begin
      if (press[k]) begin
        profile_bits = profile_bits | masks[k];
      end
    end
  end

  always_comb begin
    fixed_bits = 16'h0000;
    if (face_hat_byte[4]) fixed_bits = fixed_bits | BTN_X;
    if (face_hat_byte[5]) fixed_bits = fixed_bits | BTN_A;
    if (face_hat_byte[6]) fixed_bits = fixed_bits | BTN_B;
    if (face_hat_byte[7]) fixed_bits = fixed_bits | BTN_Y;
    if (shoulder_byte[0]) fixed_bits = fixed_bits | BTN_LSHOULDER;
    if (shoulder_byte[1]) fixed_bits = fixed_bits | BTN_RSHOULDER;
    if (shoulder_byte[4]) fixed_bits = fixed_bits | BTN_BACK;
    if (shoulder_byte[5]) fixed_bits = fixed_bits | BTN_START;
    if (shoulder_byte[6]) fixed_bits = fixed_bits | BTN_LTHUMB;
    if (shoulder_byte[7]) fixed_bits = fixed_bits | BTN_RTHUMB;
  end

  always_comb begin
    if (!mode.profile) begin
      button_bits = fixed_bits | dpad_bits;
    end else if (mode.hat_stick) begin
      // hat goes to the left stick, no d-pad bits
      button_bits = profile_bits;
    end else begin
      button_bits = profile_bits | dpad_bits;
    end
  end

endmodule

@@ rtl/core/gamepad_report_translator_unit.sv @@
// top level: config registers, input register, translation logic, result register
`timescale 1ns / 1ps

// Translates one controller report per clock. An item is taken on any edge with
// start high (busy is always low). It passes through the input register, the
// translation logic and the result register, then sits on the result ports with
// done high for one cycle. Results cannot be held off, so the receiver must take
// each one in the cycle done is high. Config writes (cfg_ready always high)
// should only be made while no item is in flight.
module gamepad_report_translator_unit
  import grt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  left_x_raw,
  input  logic [7:0]  left_y_raw,
  input  logic [7:0]  right_x_raw,
  input  logic [7:0]  right_y_raw,
  input  logic [7:0]  left_trigger_raw,
  input  logic [7:0]  right_trigger_raw,
  input  logic [7:0]  face_hat_byte,
  input  logic [7:0]  shoulder_byte,
  input  logic [7:0]  extra_byte,
  input  logic [23:0] touch_bytes,
  input  logic [7:0]  status_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        done,
  output logic [15:0] button_bits,
  output logic signed [15:0] thumb_left_x,
  output logic signed [15:0] thumb_left_y,
  output logic signed [15:0] thumb_right_x,
  output logic signed [15:0] thumb_right_y,
  output logic [7:0]  trigger_left,
  output logic [7:0]  trigger_right,
  output logic [6:0]  battery_percent
);

  mode_t    mode;
  map_cfg_t map;

  // input register
  logic        stage_valid;
  logic [7:0]  s_lx, s_ly, s_rx, s_ry, s_lt, s_rt;
  logic [7:0]  s_face, s_sh, s_ex, s_stat;
  logic [23:0] s_touch;

  logic [15:0] btn_next;
  logic [15:0] lx_next, ly_next, rx_next, ry_next;
  logic [7:0]  tl_next, tr_next;
  logic [6:0]  bat_next;
  logic [8:0]  bat_raw;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
      map  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE: mode   <= mode_t'(cfg_data[3:0]);
        REG_MAP0: map.w0 <= cfg_data;
        REG_MAP1: map.w1 <= cfg_data;
        REG_MAP2: map.w2 <= cfg_data;
        REG_MAP3: map.w3 <= cfg_data;
        REG_MAP4: map.w4 <= cfg_data[15:0];
        default: ;  // unused index
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else begin
      stage_valid <= start && !busy;
    end
    if (start && !busy) begin
      s_lx    <= left_x_raw;
      s_ly    <= left_y_raw;
      s_rx    <= right_x_raw;
      s_ry    <= right_y_raw;
      s_lt    <= left_trigger_raw;
      s_rt    <= right_trigger_raw;
      s_face  <= face_hat_byte;
      s_sh    <= shoulder_byte;
      s_ex    <= extra_byte;
      s_touch <= touch_bytes;
      s_stat  <= status_byte;
    end
  end

  grt_buttons u_buttons (
    .mode          (mode),
    .map           (map),
    .face_hat_byte (s_face),
    .shoulder_byte (s_sh),
    .extra_byte    (s_ex),
    .touch_bytes   (s_touch),
    .button_bits   (btn_next)
  );

  // raw*257 duplicates the byte; X adds half scale, Y is 0x7fff minus that
  assign rx_next = {s_rx, s_rx} ^ AX_SIGN_FLIP;
  assign ry_next = ~{s_ry, s_ry} ^ AX_SIGN_FLIP;

  always_comb begin
    lx_next = {s_lx, s_lx} ^ AX_SIGN_FLIP;
    ly_next = ~{s_ly, s_ly} ^ AX_SIGN_FLIP;
    if (mode.profile && mode.hat_stick) begin
      unique case (s_face[3:0])
        HAT_UP:         ly_next = AX_POS_FULL;
        HAT_UP_RIGHT:   begin ly_next = AX_DIAG_Y;     lx_next = AX_DIAG_XR;     end
        HAT_RIGHT:      lx_next = AX_POS_FULL;
        HAT_DOWN_RIGHT: begin ly_next = AX_DIAG_Y_NEG; lx_next = AX_DIAG_XR;     end
        HAT_DOWN:       ly_next = AX_NEG_FULL;
        HAT_DOWN_LEFT:  begin ly_next = AX_DIAG_Y_NEG; lx_next = AX_DIAG_XL_NEG; end
        HAT_LEFT:       lx_next = AX_NEG_FULL;
        HAT_UP_LEFT:    begin ly_next = AX_DIAG_Y;     lx_next = AX_DIAG_XL_NEG; end
        default: ;  // neutral keeps the stick bytes
      endcase
    end
  end

  assign tl_next = mode.short_trig ? ({2'b00, s_lt[7:2]} + TRIG_SHORT_BASE) : s_lt;
  assign tr_next = mode.short_trig ? ({2'b00, s_rt[7:2]} + TRIG_SHORT_BASE) : s_rt;

  // nibble * 12.5 rounded down, as (n*25) >> 1, saturated at BATT_MAX (100)
  assign bat_raw  = ({5'd0, s_stat[3:0]} << 4) + ({5'd0, s_stat[3:0]} << 3)
                  + {5'd0, s_stat[3:0]};
  assign bat_next = (bat_raw[8:1] > {1'b0, BATT_MAX}) ? BATT_MAX : bat_raw[7:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= stage_valid;
    end
    if (stage_valid) begin
      button_bits     <= btn_next;
      thumb_left_x    <= lx_next;
      thumb_left_y    <= ly_next;
      thumb_right_x   <= rx_next;
      thumb_right_y   <= ry_next;
      trigger_left    <= tl_next;
      trigger_right   <= tr_next;
      battery_percent <= bat_next;
    end
  end

  a_stage_to_result: assert property (@(posedge clk) disable iff (rst)
    stage_valid |=> done)
    else $error("item in input register produced no result strobe");

  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(stage_valid))
    else $error("result strobe without an item in the input register");

  a_start_to_result: assert property (@(posedge clk) disable iff (rst)
    start |-> ##2 done)
    else $error("accepted item did not reach the result two cycles later");

  a_battery_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (battery_percent <= BATT_MAX))
    else $error("battery percent above saturation");

endmodule

@@ sim/tb_gamepad_report_translator_unit.sv @@
// self-checking testbench for the gamepad report translator
`timescale 1ns / 1ps

module tb_gamepad_report_translator_unit;
  import grt_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int RAND_PHASES     = 12;
  localparam int ITEMS_PER_PHASE = 96;
  localparam int AXIS_SCALE      = 257;
  localparam int AXIS_TOP        = 32767;
  localparam int DIAG_Y          = 29727;
  localparam int DIAG_X_RIGHT    = 19403;
  localparam int DIAG_X_LEFT     = 22223;
  localparam int PROFILE_BUTTONS = 17;
  localparam int SHORT_BASE      = 190;
  localparam int SPLIT_X         = 800;

  // write indexes past the last register, which the block ignores
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic [7:0]  lt;
    logic [7:0]  rt;
    logic [7:0]  face;
    logic [7:0]  shoulder;
    logic [7:0]  extra;
    logic [23:0] touch;
    logic [7:0]  status;
  } report_t;

  typedef struct packed {
    logic [15:0] buttons;
    logic [15:0] lx;
    logic [15:0] ly;
    logic [15:0] rx;
    logic [15:0] ry;
    logic [7:0]  tl;
    logic [7:0]  tr;
    logic [6:0]  battery;
  } pad_state_t;

  typedef struct packed {
    logic [3:0] mode;
    logic       load_maps;
    report_t    item;
    logic       has_want;
    pad_state_t want;
  } directed_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  report_t     item_bus = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        done;
  logic [15:0] button_bits;
  logic [15:0] thumb_left_x;
  logic [15:0] thumb_left_y;
  logic [15:0] thumb_right_x;
  logic [15:0] thumb_right_y;
  logic [7:0]  trigger_left;
  logic [7:0]  trigger_right;
  logic [6:0]  battery_percent;
  pad_state_t  pad_seen;

  // typed expectation carried along with a directed item
  logic        row_has_want = 1'b0;
  pad_state_t  row_want = '0;

  mode_t       mode_model = '0;
  map_cfg_t    maps_model = '0;
  pad_state_t  expected_pads[$];
  int          reports_sent = 0;
  int          pads_seen = 0;
  int          mismatch_count = 0;
  int          quiet_cycles = 0;

  assign pad_seen = {button_bits, thumb_left_x, thumb_left_y, thumb_right_x, thumb_right_y,
                     trigger_left, trigger_right, battery_percent};

  gamepad_report_translator_unit dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .left_x_raw       (item_bus.lx),
    .left_y_raw       (item_bus.ly),
    .right_x_raw      (item_bus.rx),
    .right_y_raw      (item_bus.ry),
    .left_trigger_raw (item_bus.lt),
    .right_trigger_raw(item_bus.rt),
    .face_hat_byte    (item_bus.face),
    .shoulder_byte    (item_bus.shoulder),
    .extra_byte       (item_bus.extra),
    .touch_bytes      (item_bus.touch),
    .status_byte      (item_bus.status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .done             (done),
    .button_bits      (button_bits),
    .thumb_left_x     (thumb_left_x),
    .thumb_left_y     (thumb_left_y),
    .thumb_right_x    (thumb_right_x),
    .thumb_right_y    (thumb_right_y),
    .trigger_left     (trigger_left),
    .trigger_right    (trigger_right),
    .battery_percent  (battery_percent)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // fields: lx ly rx ry lt rt face shoulder extra touch status
  directed_row_t directed_rows [25] = '{
    // reset config, all bytes zero: hat up, sticks at their ends
    '{4'h0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 24'h000000,
      8'h00}, 1'b1, '{16'h0001, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 8'h00, 8'h00, 7'd0}},
    // all bytes ones: neutral hat, every fixed button, battery saturates
    '{4'h0, 1'b0, '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 24'hFFFFFF,
      8'hFF}, 1'b1, '{16'hF3F0, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 8'hFF, 8'hFF, 7'd100}},
    // neutral hat 8, battery nibble 8 is exactly full
    '{4'h0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 24'h000000,
      8'h08}, 1'b1, '{16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 8'h00, 8'h00, 7'd100}},
    // hat 9 is neutral, extra byte ignored outside profile mode
    '{4'h0, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'hFF, 24'h000000,
      8'h09}, 1'b1, '{16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 8'h00, 8'h00, 7'd100}},
    '{4'h0, 1'b0, '{8'h80, 8'h7F, 8'h7F, 8'h80, 8'h12, 8'h34, 8'h25, 8'h11, 8'h00, 24'h000000,
      8'h01}, 1'b0, '0},
    '{4'h0, 1'b0, '{8'h01, 8'hFE, 8'h40, 8'hC0, 8'h55, 8'hAA, 8'h46, 8'h22, 8'h00, 24'h031F00,
      8'h0C}, 1'b0, '0},
    '{4'h0, 1'b0, '{8'hFE, 8'h01, 8'hC0, 8'h40, 8'hAA, 8'h55, 8'h97, 8'hC4, 8'h00, 24'h000000,
      8'h07}, 1'b0, '0},
    // short triggers at both ends
    '{4'h1, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h08, 8'h00, 8'h00, 24'h000000,
      8'h00}, 1'b1, '{16'h0000, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 8'd190, 8'd253, 7'd0}},
    '{4'h1, 1'b0, '{8'h33, 8'hCC, 8'h5A, 8'hA5, 8'h03, 8'h04, 8'h1F, 8'h30, 8'h00, 24'h000000,
      8'h0F}, 1'b0, '0},
    // profile mode with masks still at reset: only the d-pad gets through
    '{4'h2, 1'b0, '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hF0, 8'hFF, 8'hFF, 24'h000000,
      8'h00}, 1'b1, '{16'h0001, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 8'h00, 8'h00, 7'd0}},
    '{4'h2, 1'b1, '{8'h20, 8'hE0, 8'h60, 8'hA0, 8'h10, 8'hF0, 8'hF6, 8'hF3, 8'hF7, 24'h000000,
      8'h05}, 1'b0, '0},
    // hat up in profile mode ORs the d-pad bit
    '{4'h2, 1'b0, '{8'h80, 8'h80, 8'h80, 8'h80, 8'h00, 8'h00, 8'h50, 8'h01, 8'h00, 24'hFFFFFF,
      8'h0A}, 1'b0, '0},
    // touchpad split: x 799 selects, 800 starts, no touch, x 4095
    '{4'hA, 1'b0, '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 24'h031F7F,
      8'h02}, 1'b0, '0},
    '{4'hA, 1'b0, '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, 24'h032000,
      8'h03}, 1'b0, '0},
    '{4'hA, 1'b0, '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h03, 8'h00, 8'h00, 24'h000080,
      8'h04}, 1'b0, '0},
    '{4'hA, 1'b0, '{8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h04, 8'h30, 8'h00, 24'hFFFF7F,
      8'h06}, 1'b0, '0},
    // hat drives the left stick, every direction and neutral
    '{4'hF, 1'b0, '{8'h10, 8'h20, 8'h30, 8'h40, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 24'h000080,
      8'h0B}, 1'b0, '0},
    '{4'hF, 1'b0, '{8'h10, 8'h20, 8'h30, 8'h40, 8'h00, 8'hFF, 8'h01, 8'h00, 8'h01, 24'h000080,
      8'h0D}, 1'b0, '0},
    '{4'hF, 1'b0, '{8'h10, 8'h20, 8'h30, 8'h40, 8'h00, 8'hFF, 8'h02, 8'h00, 8'h02, 24'h000080,
      8'h0E}, 1'b0, '0},
    '{4'hF, 1'b0, '{8'h10, 8'h20, 8'h30, 8'h40, 8'h00, 8'hFF, 8'h03, 8'h00, 8'h04, 24'h000000,
      8'h00}, 1'b0, '0},
    '{4'hF, 1'b0, '{8'hF0, 8'hE0, 8'hD0, 8'hC0, 8'h00, 8'hFF, 8'h04, 8'h00, 8'h10, 24'h000080,
      8'h01}, 1'b0, '0},
    '{4'hF, 1'b0, '{8'hF0, 8'hE0, 8'hD0, 8'hC0, 8'h00, 8'hFF, 8'h05, 8'h10, 8'h20, 24'h000080,
      8'h02}, 1'b0, '0},
    '{4'hF, 1'b0, '{8'hF0, 8'hE0, 8'hD0, 8'hC0, 8'h00, 8'hFF, 8'h06, 8'h00, 8'h40, 24'h000080,
      8'h03}, 1'b0, '0},
    '{4'hF, 1'b0, '{8'hF0, 8'hE0, 8'hD0, 8'hC0, 8'h00, 8'hFF, 8'h07, 8'h00, 8'h80, 24'h000080,
      8'h04}, 1'b0, '0},
    '{4'hF, 1'b0, '{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h00, 8'hFF, 8'hF8, 8'hFF, 8'hFF, 24'h7FFF00,
      8'h05}, 1'b0, '0}
  };

  function automatic pad_state_t translate_report(input report_t r, input mode_t m,
                                                  input map_cfg_t maps);
    pad_state_t   s;
    logic [15:0]  dpad;
    logic [11:0]  touch_x;
    logic         touching;
    logic         sel;
    logic         sta;
    logic [16:0]  pressed;
    logic [271:0] mask_bits;
    int           batt;
    mask_bits = maps;
    s.lx = 16'(int'(r.lx) * AXIS_SCALE + 32'h8000);
    s.ly = 16'(AXIS_TOP - int'(r.ly) * AXIS_SCALE);
    s.rx = 16'(int'(r.rx) * AXIS_SCALE + 32'h8000);
    s.ry = 16'(AXIS_TOP - int'(r.ry) * AXIS_SCALE);
    s.tl = m.short_trig ? 8'(int'(r.lt >> 2) + SHORT_BASE) : r.lt;
    s.tr = m.short_trig ? 8'(int'(r.rt >> 2) + SHORT_BASE) : r.rt;
    batt = int'(r.status[3:0]) * 25 / 2;
    s.battery = (batt > 100) ? 7'd100 : 7'(batt);
    case (r.face[3:0])
      HAT_UP:         dpad = BTN_UP;
      HAT_UP_RIGHT:   dpad = BTN_UP | BTN_RIGHT;
      HAT_RIGHT:      dpad = BTN_RIGHT;
      HAT_DOWN_RIGHT: dpad = BTN_DOWN | BTN_RIGHT;
      HAT_DOWN:       dpad = BTN_DOWN;
      HAT_DOWN_LEFT:  dpad = BTN_DOWN | BTN_LEFT;
      HAT_LEFT:       dpad = BTN_LEFT;
      HAT_UP_LEFT:    dpad = BTN_UP | BTN_LEFT;
      default:        dpad = '0;
    endcase
    s.buttons = '0;
    if (!m.profile) begin
      if (r.face[4]) s.buttons |= BTN_X;
      if (r.face[5]) s.buttons |= BTN_A;
      if (r.face[6]) s.buttons |= BTN_B;
      if (r.face[7]) s.buttons |= BTN_Y;
      if (r.shoulder[0]) s.buttons |= BTN_LSHOULDER;
      if (r.shoulder[1]) s.buttons |= BTN_RSHOULDER;
      if (r.shoulder[4]) s.buttons |= BTN_BACK;
      if (r.shoulder[5]) s.buttons |= BTN_START;
      if (r.shoulder[6]) s.buttons |= BTN_LTHUMB;
      if (r.shoulder[7]) s.buttons |= BTN_RTHUMB;
      s.buttons |= dpad;
    end else begin
      touching = !r.touch[7];
      touch_x = {r.touch[19:16], r.touch[15:8]};
      sel = r.shoulder[4] || (m.touch_split && touching && int'(touch_x) < SPLIT_X);
      sta = r.shoulder[5] || (m.touch_split && touching && int'(touch_x) >= SPLIT_X);
      // profile slot k is bit k: face, shoulders, select/start, thumbs, extra keys
      pressed = {r.extra[7], r.extra[6], r.extra[5], r.extra[4], r.extra[2], r.extra[0],
                 r.extra[1], r.shoulder[7], r.shoulder[6], sta, sel, r.shoulder[1],
                 r.shoulder[0], r.face[7:4]};
      for (int k = 0; k < PROFILE_BUTTONS; k++)
        if (pressed[k]) s.buttons |= mask_bits[k*16 +: 16];
      if (m.hat_stick) begin
        case (r.face[3:0])
          HAT_UP:         s.ly = 16'(AXIS_TOP);
          HAT_UP_RIGHT:   begin s.ly = 16'(DIAG_Y); s.lx = 16'(DIAG_X_RIGHT); end
          HAT_RIGHT:      s.lx = 16'(AXIS_TOP);
          HAT_DOWN_RIGHT: begin s.ly = 16'(-DIAG_Y); s.lx = 16'(DIAG_X_RIGHT); end
          HAT_DOWN:       s.ly = 16'(-AXIS_TOP - 1);
          HAT_DOWN_LEFT:  begin s.ly = 16'(-DIAG_Y); s.lx = 16'(-DIAG_X_LEFT); end
          HAT_LEFT:       s.lx = 16'(-AXIS_TOP - 1);
          HAT_UP_LEFT:    begin s.ly = 16'(DIAG_Y); s.lx = 16'(-DIAG_X_LEFT); end
          default:        ;
        endcase
      end else begin
        s.buttons |= dpad;
      end
    end
    return s;
  endfunction

  function automatic logic [7:0] stick_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string field, input logic [15:0] got,
                               input logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("result %0d: %s is %h, expected %h", pads_seen, field, got, want);
  endtask

  task automatic compare_pad(input pad_state_t got, input pad_state_t want);
    if (got.buttons !== want.buttons) flag_mismatch("button_bits", got.buttons, want.buttons);
    if (got.lx !== want.lx) flag_mismatch("thumb_left_x", got.lx, want.lx);
    if (got.ly !== want.ly) flag_mismatch("thumb_left_y", got.ly, want.ly);
    if (got.rx !== want.rx) flag_mismatch("thumb_right_x", got.rx, want.rx);
    if (got.ry !== want.ry) flag_mismatch("thumb_right_y", got.ry, want.ry);
    if (got.tl !== want.tl) flag_mismatch("trigger_left", 16'(got.tl), 16'(want.tl));
    if (got.tr !== want.tr) flag_mismatch("trigger_right", 16'(got.tr), 16'(want.tr));
    if (got.battery !== want.battery)
      flag_mismatch("battery_percent", 16'(got.battery), 16'(want.battery));
  endtask

  // leaves start high so a following item can go out back to back
  task automatic send_report(input report_t r, input logic has_want, input pad_state_t want);
    item_bus <= r;
    row_has_want <= has_want;
    row_want <= want;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    reports_sent++;
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pads_seen != reports_sent) @(posedge clk);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MODE: mode_model = mode_t'(cfg_data[3:0]);
          REG_MAP0: maps_model.w0 = cfg_data;
          REG_MAP1: maps_model.w1 = cfg_data;
          REG_MAP2: maps_model.w2 = cfg_data;
          REG_MAP3: maps_model.w3 = cfg_data;
          REG_MAP4: maps_model.w4 = cfg_data[15:0];
          default:  ;
        endcase
      end
      if (start && !busy)
        expected_pads.push_back(row_has_want ? row_want :
                                translate_report(item_bus, mode_model, maps_model));
      if (done) begin
        if (expected_pads.size() == 0)
          flag_mismatch("result with nothing expected", button_bits, 16'h0000);
        else
          compare_pad(pad_seen, expected_pads.pop_front());
        pads_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || (cfg_valid && cfg_ready) || done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("gamepad_report_translator_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    report_t     r;
    logic [3:0]  cur_mode;
    logic [3:0]  m;
    logic [63:0] word;
    int          burst_left;
    int          gap;
    bit          calm;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    cur_mode = 4'h0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].load_maps || directed_rows[i].mode != cur_mode) begin
        wait_idle();
        if (directed_rows[i].load_maps) begin
          write_reg(REG_MAP0, 64'h8000_4000_2000_1000);
          write_reg(REG_MAP1, 64'h0010_0020_0200_0100);
          write_reg(REG_MAP2, 64'h0800_0400_0080_0040);
          write_reg(REG_MAP3, 64'h00C0_0030_000C_0003);
          write_reg(REG_MAP4, 64'hFFFF_FFFF_FFFF_5A5A);
          write_reg(REG_SPARE_6, '1);
          write_reg(REG_SPARE_7, '1);
        end
        // upper data bits set to show they are dropped
        if (directed_rows[i].mode != cur_mode)
          write_reg(REG_MODE, {{60{1'b1}}, directed_rows[i].mode});
        cfg_valid <= 1'b0;
        cur_mode = directed_rows[i].mode;
      end
      send_report(directed_rows[i].item, directed_rows[i].has_want, directed_rows[i].want);
    end

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      wait_idle();
      case (phase)
        0:       m = 4'h0;
        1:       m = 4'hF;
        default: begin
          m = 4'($urandom);
          if ($urandom_range(0, 3) != 0) m[1] = 1'b1;
        end
      endcase
      write_reg(REG_MODE, {32'($urandom), 28'($urandom), m});
      for (int w = 0; w < 5; w++) begin
        case ($urandom_range(0, 5))
          0:       word = '0;
          1:       word = '1;
          default: word = {$urandom, $urandom};
        endcase
        write_reg(3'(REG_MAP0 + w), word);
      end
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_6 : REG_SPARE_7, {$urandom, $urandom});
      cfg_valid <= 1'b0;

      calm = (phase % 4 == 3);
      burst_left = 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap = calm ? 0 : $urandom_range(0, 6);
          if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        burst_left--;
        r.lx = stick_byte();
        r.ly = stick_byte();
        r.rx = stick_byte();
        r.ry = stick_byte();
        r.lt = stick_byte();
        r.rt = stick_byte();
        // mostly valid hat directions, some of the neutral codes above
        r.face = {4'($urandom),
                  ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8))};
        r.shoulder = 8'($urandom);
        r.extra = 8'($urandom);
        // touch x often right around the select/start split
        r.touch = {4'($urandom),
                   ($urandom_range(0, 2) == 0) ? 12'($urandom_range(796, 804)) : 12'($urandom),
                   8'($urandom)};
        r.status = 8'($urandom);
        send_report(r, 1'b0, '0);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (expected_pads.size() != 0)
      flag_mismatch("results never seen", 16'(expected_pads.size()), 16'h0000);
    if (mismatch_count == 0)
      $display("gamepad_report_translator_unit: match");
    else
      $display("gamepad_report_translator_unit: mismatch");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/grt_pkg.sv
rtl/core/grt_buttons.sv
rtl/core/gamepad_report_translator_unit.sv
sim/tb_gamepad_report_translator_unit.sv
